[rtl/epaper_pixel_drive_encoder_unit_assert.svh]
// Assertion macros used by the encoder's top-level RTL file.
`ifndef EPAPER_PIXEL_DRIVE_ENCODER_UNIT_ASSERT_SVH
`define EPAPER_PIXEL_DRIVE_ENCODER_UNIT_ASSERT_SVH

// The antecedent in this cycle requires the consequent in the same cycle.
`define EPD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The antecedent in this cycle requires the consequent in the next cycle.
`define EPD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/epdenc_pkg.sv]
// Types, tables and helper functions of the e-paper pixel drive encoder.
package epdenc_pkg;

	localparam int NumLevels = 8;
	localparam int NumPhases = 9;
	localparam int RowW      = 18;
	localparam int RegAddrW  = 5;

	typedef logic [RowW-1:0] row_t;
	typedef row_t [NumLevels-1:0] rows_t;

	typedef enum logic [1:0] {
		OP_MONO    = 2'd0,
		OP_PARTIAL = 2'd1,
		OP_GRAY    = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic       two;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	typedef struct packed {
		logic pending;
	} back_status_t;

	localparam rows_t RowReset = {
		18'd43648, 18'd38912, 18'd27304, 18'd27232,
		18'd27044, 18'd26976, 18'd23168, 18'd16384
	};

	localparam logic [7:0] WhiteTab [16] = '{
		8'hFF, 8'hFE, 8'hFB, 8'hFA, 8'hEF, 8'hEE, 8'hEB, 8'hEA,
		8'hBF, 8'hBE, 8'hBB, 8'hBA, 8'hAF, 8'hAE, 8'hAB, 8'hAA
	};

	localparam logic [7:0] BlackTab [16] = '{
		8'hFF, 8'hFD, 8'hF7, 8'hF5, 8'hDF, 8'hDD, 8'hD7, 8'hD5,
		8'h7F, 8'h7D, 8'h77, 8'h75, 8'h5F, 8'h5D, 8'h57, 8'h55
	};

	function automatic logic [1:0] wave_code(rows_t rows, logic [2:0] level, logic [3:0] ph);
		row_t r;
		r = rows[level];
		if (ph >= 4'(NumPhases)) begin
			return 2'b00;
		end
		return r[{ph, 1'b0} +: 2];
	endfunction

	function automatic logic [3:0] gray_nibble(rows_t rows, logic [7:0] g, logic [3:0] ph);
		return {wave_code(rows, g[2:0], ph), wave_code(rows, g[6:4], ph)};
	endfunction

endpackage

[rtl/epdenc_regs.sv]
// APB register file holding the eight waveform rows.
module epdenc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [epdenc_pkg::RegAddrW-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output epdenc_pkg::rows_t                rows
);
	import epdenc_pkg::*;

	rows_t      rows_q;
	logic [2:0] idx;

	assign idx    = paddr[RegAddrW-1:2];
	assign pready = 1'b1;
	assign rows   = rows_q;
	assign prdata = {{(32-RowW){1'b0}}, rows_q[idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RowReset;
		end else if (psel && penable && pwrite && pready) begin
			rows_q[idx] <= pwdata[RowW-1:0];
		end
	end

endmodule

[rtl/epdenc_front.sv]
// Front end: accepts input beats, classifies the opcode and forms the drive bytes.
module epdenc_front (
	input  logic              in_valid,
	input  logic [1:0]        opcode,
	input  logic [7:0]        byte_a,
	input  logic [7:0]        byte_b,
	input  logic [3:0]        phase,
	input  logic              q_full,
	input  epdenc_pkg::rows_t rows,
	output logic              in_stall,
	output epdenc_pkg::q_push_t push
);
	import epdenc_pkg::*;

	logic [7:0] inv_a;
	logic [7:0] dw;
	logic [7:0] db;
	opcode_t    op;

	assign op       = opcode_t'(opcode);
	assign in_stall = q_full;
	assign inv_a    = ~byte_a;
	assign dw       = byte_b & ~byte_a;
	assign db       = ~byte_b & byte_a;

	always_comb begin
		push.valid        = in_valid && !q_full;
		push.entry.first  = 8'h00;
		push.entry.second = 8'h00;
		push.entry.two    = 1'b0;
		case (op)
			OP_MONO: begin
				push.entry.first  = WhiteTab[inv_a[7:4]];
				push.entry.second = WhiteTab[inv_a[3:0]];
				push.entry.two    = 1'b1;
			end
			OP_PARTIAL: begin
				push.entry.first  = WhiteTab[dw[7:4]] & BlackTab[db[7:4]];
				push.entry.second = WhiteTab[dw[3:0]] & BlackTab[db[3:0]];
				push.entry.two    = 1'b1;
			end
			OP_GRAY: begin
				push.entry.first = {gray_nibble(rows, byte_b, phase),
					gray_nibble(rows, byte_a, phase)};
			end
			default: begin
				push.valid = 1'b0;
			end
		endcase
	end

endmodule

[rtl/epdenc_queue.sv]
// Short queue between the front end and the back end.
module epdenc_queue #(
	parameter int Depth = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  epdenc_pkg::q_push_t    push,
	input  logic                   pop,
	output epdenc_pkg::q_head_t    head,
	output logic                   full,
	output logic [$clog2(Depth+1)-1:0] count
);
	import epdenc_pkg::*;

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	q_entry_t          mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full        = (count_q == CntW'(Depth));
	assign count       = count_q;
	assign head.valid  = (count_q != '0);
	assign head.entry  = mem_q[rd_ptr_q];
	assign do_push     = push.valid && !full;
	assign do_pop      = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/epdenc_back.sv]
// Back end: sends one or two drive-byte beats per queued item through an output register.
module epdenc_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  epdenc_pkg::q_head_t      head,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               drive_byte,
	output logic                     last,
	output epdenc_pkg::back_status_t status
);
	import epdenc_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       pending_q;
	logic [7:0] second_q;
	logic       advance;

	assign advance        = !valid_q || !out_stall;
	assign pop            = advance && !pending_q && head.valid;
	assign out_valid      = valid_q;
	assign drive_byte     = byte_q;
	assign last           = last_q;
	assign status.pending = pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pending_q <= 1'b0;
		end else if (advance) begin
			if (pending_q) begin
				valid_q   <= 1'b1;
				pending_q <= 1'b0;
			end else begin
				valid_q   <= head.valid;
				pending_q <= head.valid && head.entry.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pending_q) begin
				byte_q <= second_q;
				last_q <= 1'b1;
			end else if (head.valid) begin
				byte_q   <= head.entry.first;
				last_q   <= !head.entry.two;
				second_q <= head.entry.second;
			end
		end
	end

endmodule

[rtl/epaper_pixel_drive_encoder_unit.sv]
// Top level of the e-paper pixel drive encoder.
// The first beat of an item goes from the queue into the output register before it appears.
// Mono and partial items give two beats each; gray items give one beat.
// The output register sends one beat per cycle while out_stall is low, and that sets the sustained rate.
// Reset loads the waveform rows with their default values and empties the queue.
module epaper_pixel_drive_encoder_unit #(
	parameter int QueueDepth = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [epdenc_pkg::RegAddrW-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       opcode,
	input  logic [7:0]                       byte_a,
	input  logic [7:0]                       byte_b,
	input  logic [3:0]                       phase,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       drive_byte,
	output logic                             last
);
	import epdenc_pkg::*;
	`include "epaper_pixel_drive_encoder_unit_assert.svh"

	localparam int CntW = $clog2(QueueDepth + 1);

	rows_t           rows;
	q_push_t         push;
	q_head_t         head;
	logic            q_full;
	logic            pop;
	logic [CntW-1:0] q_count;
	back_status_t    status;

	epdenc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.rows   (rows)
	);

	epdenc_front u_front (
		.in_valid(in_valid),
		.opcode  (opcode),
		.byte_a  (byte_a),
		.byte_b  (byte_b),
		.phase   (phase),
		.q_full  (q_full),
		.rows    (rows),
		.in_stall(in_stall),
		.push    (push)
	);

	epdenc_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.full  (q_full),
		.count (q_count)
	);

	epdenc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive_byte(drive_byte),
		.last      (last),
		.status    (status)
	);

	`EPD_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, q_count <= CntW'(QueueDepth))
	`EPD_ASSERT_IMPL(a_pending_first, clk, arst_n, status.pending, out_valid && !last)
	`EPD_ASSERT_NEXT(a_second_follows, clk, arst_n, out_valid && !out_stall && !last,
		out_valid && last)

endmodule
